### sv/diff_drive_step_pulse_generator_defines.svh
// Assertion macros shared by the step pulse generator RTL.
// Included by the modules that check their own control logic.
`ifndef DIFF_DRIVE_STEP_PULSE_GENERATOR_DEFINES_SVH
`define DIFF_DRIVE_STEP_PULSE_GENERATOR_DEFINES_SVH

// Same-cycle implication, disabled while reset is high.
`define DDSPG_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("ddspg: same-cycle check failed");

// Next-cycle implication, disabled while reset is high.
`define DDSPG_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("ddspg: next-cycle check failed");

`endif

### sv/ddspg_pkg.sv
// Shared types and constants of the differential drive step pulse generator.
// No dependencies; every other file refers to it by scoped names.
`default_nettype none

package ddspg_pkg;

   // Field and register widths.
   localparam int TRACK_W    = 10;
   localparam int LIMIT_W    = 11;
   localparam int FLOOR_W    = 10;
   localparam int STEP_W     = 16;
   localparam int LIN_W      = 11;
   localparam int ANG_W      = 14;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 16;

   // Speeds are held exactly in units of 1/2000 mm/s.
   localparam int unsigned RATE_SCALE = 2000;
   localparam int BASE_W     = 22;   // lin * 2000, signed
   localparam int DIFF_W     = 24;   // ang * track, signed
   localparam int SUM_W      = 25;   // wheel speed before clamping, signed
   localparam int MAG_W      = 22;   // clamped speed magnitude, limit * 2000
   localparam int FLOOR2K_W  = 21;   // floor * 2000
   localparam int DIVIDEND_W = 27;   // step_const * 2000
   localparam int DIV_CNT_W  = $clog2(DIVIDEND_W + 1);

   // Decoupling queue.
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   // Request kinds.
   localparam logic REQ_VELOCITY = 1'b0;
   localparam logic REQ_TICK     = 1'b1;

   // Register indexes.
   localparam logic [CSR_IDX_W-1:0] CSR_TRACK_WIDTH = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] CSR_SPEED_LIMIT = CSR_IDX_W'(1);
   localparam logic [CSR_IDX_W-1:0] CSR_SPEED_FLOOR = CSR_IDX_W'(2);
   localparam logic [CSR_IDX_W-1:0] CSR_STEP_CONST  = CSR_IDX_W'(3);

   // Register reset values.
   localparam logic [TRACK_W-1:0] TRACK_RESET = TRACK_W'(230);
   localparam logic [LIMIT_W-1:0] LIMIT_RESET = LIMIT_W'(750);
   localparam logic [FLOOR_W-1:0] FLOOR_RESET = FLOOR_W'(10);
   localparam logic [STEP_W-1:0]  STEP_RESET  = STEP_W'(994);

   // One classified item as it travels from the front end to the back end.
   typedef struct packed {
      logic             kind;
      logic [MAG_W-1:0] left_mag;
      logic [MAG_W-1:0] right_mag;
      logic             left_neg;
      logic             right_neg;
      logic             left_slow;
      logic             right_slow;
   } entry_type;

endpackage

`default_nettype wire

### sv/diff_drive_step_pulse_generator.sv
// Top level of the differential drive step pulse generator: register file,
// front end, queue and back end. Depends on ddspg_pkg and the ddspg_* modules.
//
//   Channel | Ports            | Beat
//   --------+------------------+---------------------------------------------
//   request | req_valid/stall  | req_type, req_lin_vel_mm_s, req_ang_vel_mrad_s
//   result  | rsp_valid/stall  | enables, reverse flags and pulse levels
//   config  | csr_wr_en        | csr_index selects the register, csr_wdata
//
// The front end stalls requests until each beat is pushed; a command beat first passes the multiply and clamp steps.
// The back end answers a tick in the cycle after it pops it; a command that moves a wheel
// waits for the 27-step restoring dividers, run once per command.
// A two-entry queue lets the front end keep accepting while the back end divides.
// Reset is synchronous and active high; every result beat is held while rsp_stall is high.
`default_nettype none

module diff_drive_step_pulse_generator #(
   parameter int PERIOD_BITS = 16
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   output logic                                   req_stall,
   input  logic                                   req_type,
   input  logic signed [ddspg_pkg::LIN_W-1:0]     req_lin_vel_mm_s,
   input  logic signed [ddspg_pkg::ANG_W-1:0]     req_ang_vel_mrad_s,
   output logic                                   rsp_valid,
   input  logic                                   rsp_stall,
   output logic                                   rsp_left_enable,
   output logic                                   rsp_right_enable,
   output logic                                   rsp_left_reverse,
   output logic                                   rsp_right_reverse,
   output logic                                   rsp_left_pulse,
   output logic                                   rsp_right_pulse,
   input  logic                                   csr_wr_en,
   input  logic        [ddspg_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic        [ddspg_pkg::CSR_DATA_W-1:0] csr_wdata
);

   logic [ddspg_pkg::TRACK_W-1:0] track_ff, track_in;
   logic [ddspg_pkg::LIMIT_W-1:0] limit_ff, limit_in;
   logic [ddspg_pkg::FLOOR_W-1:0] floor_ff, floor_in;
   logic [ddspg_pkg::STEP_W-1:0]  step_ff, step_in;
   logic                          q_push, q_full, q_pop, q_valid;
   ddspg_pkg::entry_type           push_entry, q_head;

   // Configuration register writes.
   always_comb begin
      track_in = track_ff;
      limit_in = limit_ff;
      floor_in = floor_ff;
      step_in  = step_ff;
      if (csr_wr_en) begin
         case (csr_index)
            ddspg_pkg::CSR_TRACK_WIDTH: track_in = csr_wdata[ddspg_pkg::TRACK_W-1:0];
            ddspg_pkg::CSR_SPEED_LIMIT: limit_in = csr_wdata[ddspg_pkg::LIMIT_W-1:0];
            ddspg_pkg::CSR_SPEED_FLOOR: floor_in = csr_wdata[ddspg_pkg::FLOOR_W-1:0];
            ddspg_pkg::CSR_STEP_CONST:  step_in  = csr_wdata[ddspg_pkg::STEP_W-1:0];
            default: begin
               step_in = step_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         track_ff <= ddspg_pkg::TRACK_RESET;
         limit_ff <= ddspg_pkg::LIMIT_RESET;
         floor_ff <= ddspg_pkg::FLOOR_RESET;
         step_ff  <= ddspg_pkg::STEP_RESET;
      end else begin
         track_ff <= track_in;
         limit_ff <= limit_in;
         floor_ff <= floor_in;
         step_ff  <= step_in;
      end
   end

   ddspg_front u_front (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_type           (req_type),
      .req_lin_vel_mm_s   (req_lin_vel_mm_s),
      .req_ang_vel_mrad_s (req_ang_vel_mrad_s),
      .track_width_mm     (track_ff),
      .speed_limit_mm_s   (limit_ff),
      .speed_floor_mm_s   (floor_ff),
      .q_full             (q_full),
      .q_push             (q_push),
      .q_entry            (push_entry)
   );

   ddspg_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_entry (push_entry),
      .full       (q_full),
      .pop        (q_pop),
      .not_empty  (q_valid),
      .head       (q_head)
   );

   ddspg_back #(
      .PERIOD_BITS (PERIOD_BITS)
   ) u_back (
      .clock             (clock),
      .reset             (reset),
      .step_const        (step_ff),
      .q_valid           (q_valid),
      .q_head            (q_head),
      .q_pop             (q_pop),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_left_enable   (rsp_left_enable),
      .rsp_right_enable  (rsp_right_enable),
      .rsp_left_reverse  (rsp_left_reverse),
      .rsp_right_reverse (rsp_right_reverse),
      .rsp_left_pulse    (rsp_left_pulse),
      .rsp_right_pulse   (rsp_right_pulse)
   );

endmodule

`default_nettype wire

### sv/ddspg_queue.sv
// Short FIFO of classified items between the front end and the back end.
// Depends on ddspg_pkg for the entry type and depth.
`default_nettype none
`include "diff_drive_step_pulse_generator_defines.svh"

module ddspg_queue (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  ddspg_pkg::entry_type push_entry,
   output logic                full,
   input  logic                pop,
   output logic                not_empty,
   output ddspg_pkg::entry_type head
);

   ddspg_pkg::entry_type                  entry_ff [ddspg_pkg::QUEUE_DEPTH];
   logic [ddspg_pkg::QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [ddspg_pkg::QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [ddspg_pkg::QCNT_W-1:0] count_ff, count_in;

   assign full      = (count_ff == ddspg_pkg::QCNT_W'(ddspg_pkg::QUEUE_DEPTH));
   assign not_empty = (count_ff != '0);
   assign head      = entry_ff[rd_ptr_ff];

   // Pointer and fill count updates.
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == ddspg_pkg::QPTR_W'(ddspg_pkg::QUEUE_DEPTH - 1))
                     ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == ddspg_pkg::QPTR_W'(ddspg_pkg::QUEUE_DEPTH - 1))
                     ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Entry storage needs no reset.
   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_entry;
      end
   end

   // The front end never writes a full queue and the back end never reads an empty one.
   `DDSPG_ASSERT_IMPL(a_no_overflow, clock, reset, push, !full)
   `DDSPG_ASSERT_IMPL(a_no_underflow, clock, reset, pop, not_empty)

endmodule

`default_nettype wire

### sv/ddspg_front.sv
// Front end: accepts request beats, forms both wheel speeds, clamps them
// and classifies them against the floor. Depends on ddspg_pkg.
`default_nettype none

module ddspg_front (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   output logic                                   req_stall,
   input  logic                                   req_type,
   input  logic signed [ddspg_pkg::LIN_W-1:0]     req_lin_vel_mm_s,
   input  logic signed [ddspg_pkg::ANG_W-1:0]     req_ang_vel_mrad_s,
   input  logic        [ddspg_pkg::TRACK_W-1:0]   track_width_mm,
   input  logic        [ddspg_pkg::LIMIT_W-1:0]   speed_limit_mm_s,
   input  logic        [ddspg_pkg::FLOOR_W-1:0]   speed_floor_mm_s,
   input  logic                                   q_full,
   output logic                                   q_push,
   output ddspg_pkg::entry_type                    q_entry
);

   typedef enum logic [1:0] {
      F_IDLE,
      F_MUL,
      F_CLAMP,
      F_PUSH
   } state_type;

   localparam logic signed [ddspg_pkg::BASE_W-1:0] VEL_SCALE =
      ddspg_pkg::BASE_W'(ddspg_pkg::RATE_SCALE);

   state_type                                  state_ff, state_in;
   logic                                       kind_ff, kind_in;
   logic signed [ddspg_pkg::LIN_W-1:0]         lin_ff, lin_in;
   logic signed [ddspg_pkg::ANG_W-1:0]         ang_ff, ang_in;
   logic signed [ddspg_pkg::BASE_W-1:0]        base_ff, base_in;
   logic signed [ddspg_pkg::DIFF_W-1:0]        diff_ff, diff_in;
   logic        [ddspg_pkg::MAG_W-1:0]         lim_ff, lim_in;
   logic        [ddspg_pkg::FLOOR2K_W-1:0]     floor_ff, floor_in;
   logic        [ddspg_pkg::MAG_W-1:0]         l_mag_ff, l_mag_in, r_mag_ff, r_mag_in;
   logic                                       l_neg_ff, l_neg_in, r_neg_ff, r_neg_in;
   logic signed [ddspg_pkg::SUM_W-1:0]         sum_l, sum_r;
   logic signed [ddspg_pkg::DIFF_W-1:0]        track_ext;
   logic                                       accept;

   // Magnitude after clamping to the limit.
   function automatic logic [ddspg_pkg::MAG_W-1:0] wheel_mag(
      input logic signed [ddspg_pkg::SUM_W-1:0] s,
      input logic        [ddspg_pkg::MAG_W-1:0] lim);
      logic [ddspg_pkg::SUM_W-1:0] abs_v;
      abs_v = s[ddspg_pkg::SUM_W-1] ? unsigned'(-s) : unsigned'(s);
      wheel_mag = (abs_v > ddspg_pkg::SUM_W'(lim)) ? lim : ddspg_pkg::MAG_W'(abs_v);
   endfunction

   // A clamped speed is negative unless the limit forces it to zero.
   function automatic logic wheel_neg(
      input logic signed [ddspg_pkg::SUM_W-1:0] s,
      input logic        [ddspg_pkg::MAG_W-1:0] lim);
      wheel_neg = s[ddspg_pkg::SUM_W-1] && (lim != '0);
   endfunction

   assign accept    = req_valid && !req_stall;
   assign req_stall = (state_ff != F_IDLE);
   assign track_ext = signed'(ddspg_pkg::DIFF_W'(track_width_mm));

   // Wheel speeds from the registered products.
   assign sum_l = ddspg_pkg::SUM_W'(base_ff) - ddspg_pkg::SUM_W'(diff_ff);
   assign sum_r = ddspg_pkg::SUM_W'(base_ff) + ddspg_pkg::SUM_W'(diff_ff);

   // Datapath: every stage recomputes from the held beat, so no enables are needed.
   always_comb begin
      kind_in  = accept ? req_type : kind_ff;
      lin_in   = accept ? req_lin_vel_mm_s : lin_ff;
      ang_in   = accept ? req_ang_vel_mrad_s : ang_ff;
      base_in  = ddspg_pkg::BASE_W'(lin_ff) * VEL_SCALE;
      diff_in  = ddspg_pkg::DIFF_W'(ang_ff) * track_ext;
      lim_in   = ddspg_pkg::MAG_W'(speed_limit_mm_s) *
                 ddspg_pkg::MAG_W'(ddspg_pkg::RATE_SCALE);
      floor_in = ddspg_pkg::FLOOR2K_W'(speed_floor_mm_s) *
                 ddspg_pkg::FLOOR2K_W'(ddspg_pkg::RATE_SCALE);
      l_mag_in = wheel_mag(sum_l, lim_ff);
      r_mag_in = wheel_mag(sum_r, lim_ff);
      l_neg_in = wheel_neg(sum_l, lim_ff);
      r_neg_in = wheel_neg(sum_r, lim_ff);
   end

   // Queue entry, classified against the floor.
   always_comb begin
      q_push             = (state_ff == F_PUSH) && !q_full;
      q_entry.kind       = kind_ff;
      q_entry.left_mag   = l_mag_ff;
      q_entry.right_mag  = r_mag_ff;
      q_entry.left_neg   = l_neg_ff;
      q_entry.right_neg  = r_neg_ff;
      q_entry.left_slow  = (l_mag_ff < ddspg_pkg::MAG_W'(floor_ff));
      q_entry.right_slow = (r_mag_ff < ddspg_pkg::MAG_W'(floor_ff));
   end

   // Sequencer: ticks go straight to the queue, commands pass the two arithmetic steps.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         F_IDLE: begin
            if (accept) begin
               state_in = (req_type == ddspg_pkg::REQ_TICK) ? F_PUSH : F_MUL;
            end
         end
         F_MUL: begin
            state_in = F_CLAMP;
         end
         F_CLAMP: begin
            state_in = F_PUSH;
         end
         F_PUSH: begin
            if (!q_full) begin
               state_in = F_IDLE;
            end
         end
         default: begin
            state_in = F_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= F_IDLE;
      end else begin
         state_ff <= state_in;
      end
      kind_ff  <= kind_in;
      lin_ff   <= lin_in;
      ang_ff   <= ang_in;
      base_ff  <= base_in;
      diff_ff  <= diff_in;
      lim_ff   <= lim_in;
      floor_ff <= floor_in;
      l_mag_ff <= l_mag_in;
      r_mag_ff <= r_mag_in;
      l_neg_ff <= l_neg_in;
      r_neg_ff <= r_neg_in;
   end

endmodule

`default_nettype wire

### sv/ddspg_divider.sv
// Restoring divider, one quotient bit per cycle.
// Depends on ddspg_pkg for the dividend and divisor widths.
`default_nettype none

module ddspg_divider (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 start,
   input  logic [ddspg_pkg::DIVIDEND_W-1:0]     dividend,
   input  logic [ddspg_pkg::MAG_W-1:0]          divisor,
   output logic                                 done,
   output logic [ddspg_pkg::DIVIDEND_W-1:0]     quotient
);

   logic                                  busy_ff, busy_in;
   logic                                  done_ff, done_in;
   logic [ddspg_pkg::DIV_CNT_W-1:0]       count_ff, count_in;
   logic [ddspg_pkg::MAG_W-1:0]           rem_ff, rem_in;
   logic [ddspg_pkg::DIVIDEND_W-1:0]      shift_ff, shift_in;
   logic [ddspg_pkg::MAG_W-1:0]           divisor_ff, divisor_in;
   logic [ddspg_pkg::MAG_W:0]             rem_shift;
   logic [ddspg_pkg::MAG_W:0]             trial;
   logic                                  fits;

   assign done     = done_ff;
   assign quotient = shift_ff;

   // One trial subtraction: the dividend shifts out at the top, quotient bits in at the bottom.
   assign rem_shift = {rem_ff, shift_ff[ddspg_pkg::DIVIDEND_W-1]};
   assign trial     = rem_shift - {1'b0, divisor_ff};
   assign fits      = (rem_shift >= {1'b0, divisor_ff});

   always_comb begin
      busy_in    = busy_ff;
      done_in    = 1'b0;
      count_in   = count_ff;
      rem_in     = rem_ff;
      shift_in   = shift_ff;
      divisor_in = divisor_ff;
      if (start) begin
         busy_in    = 1'b1;
         count_in   = ddspg_pkg::DIV_CNT_W'(ddspg_pkg::DIVIDEND_W);
         rem_in     = '0;
         shift_in   = dividend;
         divisor_in = divisor;
      end else if (busy_ff) begin
         rem_in   = fits ? trial[ddspg_pkg::MAG_W-1:0] : rem_shift[ddspg_pkg::MAG_W-1:0];
         shift_in = {shift_ff[ddspg_pkg::DIVIDEND_W-2:0], fits};
         count_in = count_ff - 1'b1;
         if (count_ff == ddspg_pkg::DIV_CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         done_ff  <= 1'b0;
         count_ff <= '0;
      end else begin
         busy_ff  <= busy_in;
         done_ff  <= done_in;
         count_ff <= count_in;
      end
      rem_ff     <= rem_in;
      shift_ff   <= shift_in;
      divisor_ff <= divisor_in;
   end

endmodule

`default_nettype wire

### sv/ddspg_back.sv
// Back end: carries out ticks and commands, holds the wheel state and the
// result register. Depends on ddspg_pkg and ddspg_divider.
`default_nettype none
`include "diff_drive_step_pulse_generator_defines.svh"

module ddspg_back #(
   parameter int PERIOD_BITS = 16
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic [ddspg_pkg::STEP_W-1:0]       step_const,
   input  logic                               q_valid,
   input  ddspg_pkg::entry_type                q_head,
   output logic                               q_pop,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output logic                               rsp_left_enable,
   output logic                               rsp_right_enable,
   output logic                               rsp_left_reverse,
   output logic                               rsp_right_reverse,
   output logic                               rsp_left_pulse,
   output logic                               rsp_right_pulse
);

   typedef enum logic [1:0] {
      B_IDLE,
      B_START,
      B_WAIT,
      B_FIN
   } state_type;

   localparam int CAP_W = (PERIOD_BITS > ddspg_pkg::DIVIDEND_W) ?
                          PERIOD_BITS : ddspg_pkg::DIVIDEND_W;
   localparam logic [PERIOD_BITS-1:0] PMASK = '1;

   state_type                              state_ff, state_in;
   logic [PERIOD_BITS-1:0]                 hp_l_ff, hp_l_in, hp_r_ff, hp_r_in;
   logic [PERIOD_BITS-1:0]                 cnt_l_ff, cnt_l_in, cnt_r_ff, cnt_r_in;
   logic                                   lvl_l_ff, lvl_l_in, lvl_r_ff, lvl_r_in;
   logic                                   en_l_ff, en_l_in, en_r_ff, en_r_in;
   logic                                   dir_l_ff, dir_l_in, dir_r_ff, dir_r_in;
   logic                                   rsp_valid_ff, rsp_valid_in;
   logic                                   rsp_en_l_ff, rsp_en_r_ff;
   logic                                   rsp_dir_l_ff, rsp_dir_r_ff;
   logic                                   rsp_lvl_l_ff, rsp_lvl_r_ff;
   logic [ddspg_pkg::MAG_W-1:0]            mag_l_ff, mag_l_in, mag_r_ff, mag_r_in;
   logic                                   neg_l_ff, neg_l_in, neg_r_ff, neg_r_in;
   logic [ddspg_pkg::DIVIDEND_W-1:0]       dividend_ff, dividend_in;
   logic                                   div_start;
   logic                                   l_done, r_done;
   logic [ddspg_pkg::DIVIDEND_W-1:0]       q_l, q_r;
   logic                                   out_free;
   logic                                   emit;
   logic                                   wrap_l, wrap_r;

   // Half-period from a quotient, saturated; a standing wheel gets the cap.
   function automatic logic [PERIOD_BITS-1:0] half_period(
      input logic [ddspg_pkg::DIVIDEND_W-1:0] q,
      input logic [ddspg_pkg::MAG_W-1:0]      m);
      logic [CAP_W-1:0] q_ext;
      q_ext = CAP_W'(q);
      half_period = ((m == '0) || (q_ext > CAP_W'(PMASK))) ? PMASK : PERIOD_BITS'(q);
   endfunction

   // One divider per wheel; both run in lockstep.
   ddspg_divider u_div_left (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (dividend_ff),
      .divisor  (mag_l_ff),
      .done     (l_done),
      .quotient (q_l)
   );

   ddspg_divider u_div_right (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (dividend_ff),
      .divisor  (mag_r_ff),
      .done     (r_done),
      .quotient (q_r)
   );

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign q_pop     = (state_ff == B_IDLE) && q_valid && out_free;
   assign div_start = (state_ff == B_START);
   assign wrap_l    = (cnt_l_ff > hp_l_ff);
   assign wrap_r    = (cnt_r_ff > hp_r_ff);

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_left_enable   = rsp_en_l_ff;
   assign rsp_right_enable  = rsp_en_r_ff;
   assign rsp_left_reverse  = rsp_dir_l_ff;
   assign rsp_right_reverse = rsp_dir_r_ff;
   assign rsp_left_pulse    = rsp_lvl_l_ff;
   assign rsp_right_pulse   = rsp_lvl_r_ff;

   // Next state of the wheels and of the sequencer.
   always_comb begin
      state_in    = state_ff;
      hp_l_in     = hp_l_ff;
      hp_r_in     = hp_r_ff;
      cnt_l_in    = cnt_l_ff;
      cnt_r_in    = cnt_r_ff;
      lvl_l_in    = lvl_l_ff;
      lvl_r_in    = lvl_r_ff;
      en_l_in     = en_l_ff;
      en_r_in     = en_r_ff;
      dir_l_in    = dir_l_ff;
      dir_r_in    = dir_r_ff;
      mag_l_in    = mag_l_ff;
      mag_r_in    = mag_r_ff;
      neg_l_in    = neg_l_ff;
      neg_r_in    = neg_r_ff;
      dividend_in = dividend_ff;
      emit        = 1'b0;
      case (state_ff)
         B_IDLE: begin
            if (q_pop) begin
               if (q_head.kind == ddspg_pkg::REQ_TICK) begin
                  // A counter past its half-period restarts and flips the level.
                  cnt_l_in = wrap_l ? PERIOD_BITS'(1) : cnt_l_ff + 1'b1;
                  cnt_r_in = wrap_r ? PERIOD_BITS'(1) : cnt_r_ff + 1'b1;
                  lvl_l_in = lvl_l_ff ^ wrap_l;
                  lvl_r_in = lvl_r_ff ^ wrap_r;
                  emit     = 1'b1;
               end else begin
                  en_l_in     = !q_head.left_slow;
                  en_r_in     = !q_head.right_slow;
                  mag_l_in    = q_head.left_mag;
                  mag_r_in    = q_head.right_mag;
                  neg_l_in    = q_head.left_neg;
                  neg_r_in    = q_head.right_neg;
                  dividend_in = ddspg_pkg::DIVIDEND_W'(step_const) *
                                ddspg_pkg::DIVIDEND_W'(ddspg_pkg::RATE_SCALE);
                  // Both wheels below the floor keep their periods and directions.
                  if (q_head.left_slow && q_head.right_slow) begin
                     emit = 1'b1;
                  end else begin
                     state_in = B_START;
                  end
               end
            end
         end
         B_START: begin
            state_in = B_WAIT;
         end
         B_WAIT: begin
            if (l_done) begin
               state_in = B_FIN;
            end
         end
         B_FIN: begin
            if (out_free) begin
               hp_l_in  = half_period(q_l, mag_l_ff);
               hp_r_in  = half_period(q_r, mag_r_ff);
               dir_l_in = neg_l_ff;
               dir_r_in = neg_r_ff;
               emit     = 1'b1;
               state_in = B_IDLE;
            end
         end
         default: begin
            state_in = B_IDLE;
         end
      endcase
      rsp_valid_in = emit || (rsp_valid_ff && rsp_stall);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= B_IDLE;
         hp_l_ff      <= '0;
         hp_r_ff      <= '0;
         cnt_l_ff     <= '0;
         cnt_r_ff     <= '0;
         lvl_l_ff     <= 1'b0;
         lvl_r_ff     <= 1'b0;
         en_l_ff      <= 1'b0;
         en_r_ff      <= 1'b0;
         dir_l_ff     <= 1'b0;
         dir_r_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         hp_l_ff      <= hp_l_in;
         hp_r_ff      <= hp_r_in;
         cnt_l_ff     <= cnt_l_in;
         cnt_r_ff     <= cnt_r_in;
         lvl_l_ff     <= lvl_l_in;
         lvl_r_ff     <= lvl_r_in;
         en_l_ff      <= en_l_in;
         en_r_ff      <= en_r_in;
         dir_l_ff     <= dir_l_in;
         dir_r_ff     <= dir_r_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      mag_l_ff    <= mag_l_in;
      mag_r_ff    <= mag_r_in;
      neg_l_ff    <= neg_l_in;
      neg_r_ff    <= neg_r_in;
      dividend_ff <= dividend_in;
      // The result beat shows the state after the item.
      if (emit) begin
         rsp_en_l_ff  <= en_l_in;
         rsp_en_r_ff  <= en_r_in;
         rsp_dir_l_ff <= dir_l_in;
         rsp_dir_r_ff <= dir_r_in;
         rsp_lvl_l_ff <= lvl_l_in;
         rsp_lvl_r_ff <= lvl_r_in;
      end
   end

   // The two dividers start together and must finish together.
   `DDSPG_ASSERT_IMPL(a_div_lockstep, clock, reset, l_done || r_done, l_done && r_done)
   // A finished division always leads to the update step.
   `DDSPG_ASSERT_NEXT(a_fin_after_done, clock, reset, l_done, state_ff == B_FIN)

endmodule

`default_nettype wire
